// ----- hdl/aram_pkg.sv -----
// Package for the access rate anomaly monitor: types, constants and register codes.
// Used by every module of the monitor; depends on nothing.
package aram_pkg;

    localparam int LogDepth    = 1024;
    localparam int LogAw       = $clog2(LogDepth);
    localparam int RegionSlots = 16;
    localparam int SlotW       = $clog2(RegionSlots);
    localparam int QueueDepth  = 2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] RT_MODEL   = 2'd0;
    localparam logic [1:0] RT_TENSOR  = 2'd1;
    localparam logic [1:0] RT_SCRATCH = 2'd2;
    localparam logic [1:0] RT_OTHER   = 2'd3;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_BASE_THR   = 3'd1;
    localparam logic [2:0] REG_BASE_WIN   = 3'd2;
    localparam logic [2:0] REG_OVR_MASK   = 3'd3;
    localparam logic [2:0] REG_MODEL_THR  = 3'd4;
    localparam logic [2:0] REG_TENSOR_THR = 3'd5;
    localparam logic [2:0] REG_SCRATCH_THR = 3'd6;
    localparam logic [2:0] REG_TYPE_WIN   = 3'd7;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic        active;    // event changes state
        logic [1:0]  op;
        logic [31:0] now;
        logic [47:0] address;
        logic [15:0] pid;
        logic        present;
        logic [7:0]  rgn_num;
        logic [31:0] thr;
        logic [31:0] win;
    } t_item;

    // Result item handed to the output register.
    typedef struct packed {
        logic        anomaly;
        logic [31:0] alert_count;
        logic [31:0] alert_threshold;
        logic [10:0] log_fill;
        logic [31:0] log_overflows;
        logic [31:0] sum_access;
        logic [31:0] sum_read;
        logic [31:0] sum_write;
        logic [31:0] sum_fault;
        logic [31:0] total_anomalies;
        logic [31:0] region_anomaly_total;
    } t_result;

endpackage

// ----- hdl/access_rate_anomaly_monitor.sv -----
// Access rate anomaly monitor top level: configuration registers, front and back parts.
// Depends on aram_pkg, aram_front and aram_back.
//
// Usage: event items enter on the s_axis channel (tdata: op, now, address, pid,
// region_present, rgn_num, region_type from bit 0 up). Each item gives exactly one
// result item on m_axis, in order. The block takes one item per cycle while the
// receiver takes results; an item passes the two-entry queue and then the back
// part's registered result stage. The back part updates the log pointer, counters
// and the 16-slot region table together for each item.
// Configuration goes through the APB port, one 64-bit register at byte address 8*i;
// write it only while the block is idle. Reset clears all counters, the log pointers,
// the region table and the queue, and loads the register defaults; the log memory is
// not cleared and needs no clearing pass. When the receiver stalls, the result register
// holds, then the queue fills and s_axis_tready falls; no item is lost.
module access_rate_anomaly_monitor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // op[1:0], now[33:2], address[81:34], pid[97:82], region_present[98],
    // rgn_num[106:99], region_type[108:107], zero fill
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // anomaly[0], alert_count, alert_threshold, log_fill[75:65], log_overflows,
    // access, read, write and fault totals, total_anomalies,
    // region_anomaly_total[299:268], zero fill
    output logic [303:0]  m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    logic        r_en;
    logic [31:0] r_bthr, r_bwin, r_mthr, r_tthr, r_sthr;
    logic [2:0]  r_mask;
    logic [47:0] r_twin;
    logic [2:0]  w_idx;
    logic        w_q_valid, w_q_ready;
    aram_pkg::t_item   w_item;
    aram_pkg::t_result w_res;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0; r_bthr <= 32'd10000; r_bwin <= 32'd10; r_mask <= 3'd0;
            r_mthr <= 32'd20000; r_tthr <= 32'd10000; r_sthr <= 32'd15000;
            r_twin <= {16'd10, 16'd10, 16'd10};
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                aram_pkg::REG_ENABLE:      r_en <= pwdata[0];
                aram_pkg::REG_BASE_THR:    r_bthr <= pwdata[31:0];
                aram_pkg::REG_BASE_WIN:    r_bwin <= pwdata[31:0];
                aram_pkg::REG_OVR_MASK:    r_mask <= pwdata[2:0];
                aram_pkg::REG_MODEL_THR:   r_mthr <= pwdata[31:0];
                aram_pkg::REG_TENSOR_THR:  r_tthr <= pwdata[31:0];
                aram_pkg::REG_SCRATCH_THR: r_sthr <= pwdata[31:0];
                default:                   r_twin <= pwdata[47:0];
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (w_idx)
            aram_pkg::REG_ENABLE:      prdata = {63'd0, r_en};
            aram_pkg::REG_BASE_THR:    prdata = {32'd0, r_bthr};
            aram_pkg::REG_BASE_WIN:    prdata = {32'd0, r_bwin};
            aram_pkg::REG_OVR_MASK:    prdata = {61'd0, r_mask};
            aram_pkg::REG_MODEL_THR:   prdata = {32'd0, r_mthr};
            aram_pkg::REG_TENSOR_THR:  prdata = {32'd0, r_tthr};
            aram_pkg::REG_SCRATCH_THR: prdata = {32'd0, r_sthr};
            default:                   prdata = {16'd0, r_twin};
        endcase
    end

    aram_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[1:0]), .i_now(s_axis_tdata[33:2]),
        .i_address(s_axis_tdata[81:34]), .i_pid(s_axis_tdata[97:82]),
        .i_region_present(s_axis_tdata[98]), .i_rgn_num(s_axis_tdata[106:99]),
        .i_region_type(s_axis_tdata[108:107]),
        .i_enabled(r_en), .i_base_thr(r_bthr), .i_base_win(r_bwin), .i_ovr_mask(r_mask),
        .i_model_thr(r_mthr), .i_tensor_thr(r_tthr), .i_scratch_thr(r_sthr),
        .i_type_win(r_twin),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_item(w_item)
    );

    aram_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {4'd0, w_res.region_anomaly_total, w_res.total_anomalies,
                           w_res.sum_fault, w_res.sum_write, w_res.sum_read,
                           w_res.sum_access, w_res.log_overflows, w_res.log_fill,
                           w_res.alert_threshold, w_res.alert_count, w_res.anomaly};

endmodule

// ----- hdl/aram_front.sv -----
// Front part: accepts event items, resolves threshold and window per region type and queues them.
// Depends on aram_pkg.
module aram_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  logic [31:0]         i_now,
    input  logic [47:0]         i_address,
    input  logic [15:0]         i_pid,
    input  logic                i_region_present,
    input  logic [7:0]          i_rgn_num,
    input  logic [1:0]          i_region_type,
    input  logic                i_enabled,
    input  logic [31:0]         i_base_thr,
    input  logic [31:0]         i_base_win,
    input  logic [2:0]          i_ovr_mask,
    input  logic [31:0]         i_model_thr,
    input  logic [31:0]         i_tensor_thr,
    input  logic [31:0]         i_scratch_thr,
    input  logic [47:0]         i_type_win,
    output logic                o_valid,
    input  logic                i_ready,
    output aram_pkg::t_item     o_item
);

    aram_pkg::t_item r_q [aram_pkg::QueueDepth];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    aram_pkg::t_item w_item;
    logic            w_ovr, w_push, w_pop;
    logic [3:0]      w_mask4;

    // The type other never has an override bit.
    assign w_mask4 = {1'b0, i_ovr_mask};

    // Classification of the incoming item.
    always_comb begin
        w_ovr = w_mask4[i_region_type];
        w_item.active    = i_enabled && (i_op != aram_pkg::OP_NONE);
        w_item.op        = i_op;
        w_item.now       = i_now;
        w_item.address   = i_address;
        w_item.pid       = i_pid;
        w_item.present   = i_region_present;
        w_item.rgn_num   = i_rgn_num;
        w_item.thr       = i_base_thr;
        w_item.win       = i_base_win;
        if (w_ovr) begin
            case (i_region_type)
                aram_pkg::RT_MODEL: begin
                    w_item.thr = i_model_thr;
                    w_item.win = {16'd0, i_type_win[15:0]};
                end
                aram_pkg::RT_TENSOR: begin
                    w_item.thr = i_tensor_thr;
                    w_item.win = {16'd0, i_type_win[31:16]};
                end
                default: begin
                    w_item.thr = i_scratch_thr;
                    w_item.win = {16'd0, i_type_win[47:32]};
                end
            endcase
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    // Two-entry queue between the front and back parts.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ----- hdl/aram_back.sv -----
// Back part: ring log, global and per-region counters, windowed rate check.
// Depends on aram_pkg; ends in a registered result stage.
module aram_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aram_pkg::t_item    i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output aram_pkg::t_result  o_res
);

    logic [47:0]                r_log_addr [aram_pkg::LogDepth];
    logic [57:0]                r_log_meta [aram_pkg::LogDepth];
    logic [aram_pkg::LogAw-1:0] r_head, r_tail;
    logic [10:0]                r_count;
    logic [31:0] r_ovf, r_acc, r_rd, r_wr, r_flt, r_anom, r_wcnt, r_wstart;
    logic [31:0] r_rrd [aram_pkg::RegionSlots];
    logic [31:0] r_rwr [aram_pkg::RegionSlots];
    logic [31:0] r_rflt [aram_pkg::RegionSlots];
    logic [31:0] r_ranom [aram_pkg::RegionSlots];
    logic        r_v;
    aram_pkg::t_result r_res;

    logic [aram_pkg::SlotW-1:0] w_slot;
    logic        w_go, w_acc, w_chk, w_elapsed, w_hit, w_full;
    aram_pkg::t_result w_res;

    assign o_ready = !r_v || i_ready;
    assign w_go    = i_valid && o_ready;
    assign w_slot  = i_item.rgn_num[aram_pkg::SlotW-1:0];
    assign w_full  = (r_count == 11'(aram_pkg::LogDepth));
    assign w_acc   = i_item.active && (i_item.op != aram_pkg::OP_FAULT);
    assign w_chk   = w_acc && i_item.present;
    assign w_elapsed = (i_item.now - r_wstart) >= i_item.win;
    assign w_hit   = w_chk && w_elapsed && (r_wcnt > i_item.thr);

    // Result from the state after this item.
    always_comb begin
        w_res.anomaly         = w_hit;
        w_res.alert_count     = w_hit ? r_wcnt : 32'd0;
        w_res.alert_threshold = w_hit ? i_item.thr : 32'd0;
        w_res.log_fill        = r_count + 11'((i_item.active && !w_full) ? 1 : 0);
        w_res.log_overflows   = r_ovf + 32'((i_item.active && w_full) ? 1 : 0);
        w_res.sum_access      = r_acc + 32'(w_acc ? 1 : 0);
        w_res.sum_read        = r_rd + 32'((w_acc && i_item.op == aram_pkg::OP_READ) ? 1 : 0);
        w_res.sum_write       = r_wr + 32'((w_acc && i_item.op == aram_pkg::OP_WRITE) ? 1 : 0);
        w_res.sum_fault       = r_flt + 32'((i_item.active &&
                                             i_item.op == aram_pkg::OP_FAULT) ? 1 : 0);
        w_res.total_anomalies = r_anom + 32'(w_hit ? 1 : 0);
        w_res.region_anomaly_total = i_item.present ?
                                     (r_ranom[w_slot] + 32'(w_hit ? 1 : 0)) : 32'd0;
    end

    // Log memory writes and the result register.
    always_ff @(posedge i_clk) begin
        if (w_go && i_item.active) begin
            r_log_addr[r_head] <= i_item.address;
            r_log_meta[r_head] <= {i_item.op, (i_item.present ? i_item.rgn_num : 8'd0),
                                   i_item.pid, i_item.now};
        end
        if (w_go) begin
            r_res <= w_res;
        end
    end

    // Counters and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_ovf <= '0; r_acc <= '0; r_rd <= '0; r_wr <= '0; r_flt <= '0;
            r_anom <= '0; r_wcnt <= '0; r_wstart <= '0; r_v <= 1'b0;
            for (int k = 0; k < aram_pkg::RegionSlots; k++) begin
                r_rrd[k] <= '0; r_rwr[k] <= '0; r_rflt[k] <= '0; r_ranom[k] <= '0;
            end
        end else begin
            if (w_go) r_v <= 1'b1;
            else if (i_ready) r_v <= 1'b0;
            if (w_go && i_item.active) begin
                r_head <= r_head + aram_pkg::LogAw'(1);
                r_count <= w_res.log_fill;
                r_ovf <= w_res.log_overflows;
                if (w_full) r_tail <= r_tail + aram_pkg::LogAw'(1);
                r_acc <= w_res.sum_access;
                r_rd <= w_res.sum_read;
                r_wr <= w_res.sum_write;
                r_flt <= w_res.sum_fault;
                r_anom <= w_res.total_anomalies;
                if (i_item.present) begin
                    case (i_item.op)
                        aram_pkg::OP_READ:  r_rrd[w_slot] <= r_rrd[w_slot] + 32'd1;
                        aram_pkg::OP_WRITE: r_rwr[w_slot] <= r_rwr[w_slot] + 32'd1;
                        default: r_rflt[w_slot] <= r_rflt[w_slot] + 32'd1;
                    endcase
                end
                if (w_hit) r_ranom[w_slot] <= w_res.region_anomaly_total;
                if (w_chk) begin
                    if (w_elapsed) begin
                        r_wcnt <= 32'd1;
                        r_wstart <= i_item.now;
                    end else begin
                        r_wcnt <= r_wcnt + 32'd1;
                    end
                end
            end
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_res;

endmodule
